FILE: rtl/tlbpt_pkg.sv
// ----------------------------------------------------------------------------
// tlbpt_pkg
// Shared widths, defaults, opcodes, controller states and TLB port structs
// for the demand-paged address translator.
// ----------------------------------------------------------------------------
`default_nettype none

package tlbpt_pkg;

  localparam int TLB_ENTRIES_DEF = 16;
  localparam int PAGE_BYTES_DEF  = 256;
  localparam int PAGE_COUNT_DEF  = 256;

  localparam int ADDR_W = 16;
  localparam int BYTE_W = 8;
  localparam int TAG_W  = 8;
  localparam int CNT_W  = 32;

  // s_axis_tdata: virt_addr, load_address, load_data
  localparam int IN_TDATA_W  = 40;
  // m_axis_tdata: physical_address, data_value, tlb_hit, page_fault,
  // tlb_hit_count, page_fault_count, zero pad
  localparam int OUT_FIELD_W = ADDR_W + BYTE_W + 2 + 2 * CNT_W;
  localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;
  localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_FIELD_W;

  typedef enum logic {
    OP_TRANSLATE = 1'b0,
    OP_LOAD      = 1'b1
  } tlbpt_op_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_RESOLVE,
    S_COPY,
    S_FETCH,
    S_READ
  } tlbpt_state_t;

  typedef struct packed {
    logic             lookup;
    logic [TAG_W-1:0] lookup_tag;
    logic             fill;
    logic [TAG_W-1:0] fill_tag;
    logic [TAG_W-1:0] fill_frame;
  } tlbpt_tlb_req_t;

  typedef struct packed {
    logic             hit;
    logic [TAG_W-1:0] frame;
  } tlbpt_tlb_rsp_t;

endpackage

`default_nettype wire

FILE: rtl/tlbpt_ram.sv
// ----------------------------------------------------------------------------
// tlbpt_ram
// Simple dual-port synchronous RAM: one write port, one read port with a
// registered read that updates only on read enable.
// ----------------------------------------------------------------------------
`default_nettype none

module tlbpt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/tlbpt_tlb.sv
// ----------------------------------------------------------------------------
// tlbpt_tlb
// Fully associative TLB: tags and valid bits in flops for a parallel match,
// frame entries in a RAM read at the matching slot, FIFO fill pointer.
// ----------------------------------------------------------------------------
`default_nettype none

module tlbpt_tlb #(
  parameter int TLB_ENTRIES = tlbpt_pkg::TLB_ENTRIES_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  tlbpt_pkg::tlbpt_tlb_req_t req,
  output tlbpt_pkg::tlbpt_tlb_rsp_t rsp
);

  import tlbpt_pkg::*;

  localparam int IW = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;

  logic [TAG_W-1:0] tag [TLB_ENTRIES];
  logic [TLB_ENTRIES-1:0] valid;
  logic [IW-1:0] ptr;
  logic [IW-1:0] match_idx;
  logic match_any;
  logic hit;

  always_comb begin
    match_idx = '0;
    match_any = 1'b0;
    for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
      if (valid[i] && tag[i] == req.lookup_tag) begin
        match_idx = IW'(i);
        match_any = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      ptr   <= '0;
      hit   <= 1'b0;
    end else begin
      if (req.lookup) begin
        hit <= match_any;
      end
      if (req.fill) begin
        valid[ptr] <= 1'b1;
        ptr <= (ptr == IW'(TLB_ENTRIES - 1)) ? '0 : ptr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.fill) begin
      tag[ptr] <= req.fill_tag;
    end
  end

  tlbpt_ram #(
    .WIDTH (TAG_W),
    .DEPTH (TLB_ENTRIES),
    .AW    (IW)
  ) u_frame_ram (
    .clk   (clk),
    .we    (req.fill),
    .waddr (ptr),
    .wdata (req.fill_frame),
    .re    (req.lookup),
    .raddr (match_idx),
    .rdata (rsp.frame)
  );

  assign rsp.hit = hit;

endmodule

`default_nettype wire

FILE: rtl/tlb_page_table_translator.sv
// ----------------------------------------------------------------------------
// tlb_page_table_translator
// Order: a load writes the backing store on transfer; a translation passes
// RESOLVE then READ on a TLB hit or resident page, and RESOLVE, COPY, FETCH
// and READ on a page fault (one backing-store read and one physical-memory
// write per byte). Throughput: a load every cycle while idle; no input is
// taken mid-translation; READ loads the result register once it is free.
// Reset: synchronous; clears TLB valid bits, FIFO pointer, free frame and
// counters, then sweeps every page table entry invalid before ready.
// ----------------------------------------------------------------------------
`default_nettype none

module tlb_page_table_translator #(
  parameter int TLB_ENTRIES = tlbpt_pkg::TLB_ENTRIES_DEF,
  parameter int PAGE_BYTES  = tlbpt_pkg::PAGE_BYTES_DEF,
  parameter int PAGE_COUNT  = tlbpt_pkg::PAGE_COUNT_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // virt_addr[15:0], load_address[31:16], load_data[39:32]
  input  logic [tlbpt_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  // opcode[0]
  input  logic                               s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // physical_address[15:0], data_value[23:16], tlb_hit[24], page_fault[25],
  // tlb_hit_count[57:26], page_fault_count[89:58], zero pad
  output logic [tlbpt_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);

  import tlbpt_pkg::*;

  localparam int OFF_W     = $clog2(PAGE_BYTES);
  localparam int PAGE_W    = $clog2(PAGE_COUNT);
  localparam int MEM_AW    = OFF_W + PAGE_W;
  localparam int MEM_BYTES = PAGE_COUNT * PAGE_BYTES;

  tlbpt_state_t state, state_next;

  // input decode
  logic [ADDR_W-1:0] in_la;
  logic [ADDR_W-1:0] in_ld_addr;
  logic [BYTE_W-1:0] in_ld_data;
  logic [31:0]       la_shift;
  logic [31:0]       ld_ext;
  logic [31:0]       page_in_ext;
  logic [PAGE_W-1:0] page_in;
  logic [OFF_W-1:0]  offset_in;
  logic              in_xfer;
  logic              do_lookup;
  logic              do_load;

  assign in_la      = s_axis_tdata[15:0];
  assign in_ld_addr = s_axis_tdata[31:16];
  assign in_ld_data = s_axis_tdata[39:32];
  assign la_shift   = 32'(in_la) >> OFF_W;
  assign page_in    = la_shift[PAGE_W-1:0];
  assign offset_in  = in_la[OFF_W-1:0];
  assign ld_ext     = 32'(in_ld_addr);
  assign page_in_ext = 32'(page_in);
  assign in_xfer    = s_axis_tvalid && s_axis_tready;
  assign do_lookup  = in_xfer && (tlbpt_op_t'(s_axis_tuser) == OP_TRANSLATE);
  assign do_load    = in_xfer && (tlbpt_op_t'(s_axis_tuser) == OP_LOAD);

  // item registers
  logic [PAGE_W-1:0] page;
  logic [OFF_W-1:0]  offset;
  logic [PAGE_W-1:0] frame;
  logic [PAGE_W:0]   next_free_frame;
  logic [OFF_W:0]    copy_cnt;
  logic [OFF_W:0]    copy_cnt_m1;
  logic [PAGE_W-1:0] clear_cnt;
  logic [CNT_W-1:0]  hit_count;
  logic [CNT_W-1:0]  fault_count;
  logic              hit_flag;
  logic              fault_flag;

  // result register
  logic              out_valid;
  logic [ADDR_W-1:0] out_paddr;
  logic [BYTE_W-1:0] out_data;
  logic              out_hit;
  logic              out_fault;
  logic [CNT_W-1:0]  out_hit_count;
  logic [CNT_W-1:0]  out_fault_count;

  // TLB
  tlbpt_tlb_req_t tlb_req;
  tlbpt_tlb_rsp_t tlb_rsp;
  logic [31:0]    tlb_frame_ext;
  logic [31:0]    page_ext;
  logic [31:0]    frame_sel_ext;

  // page table
  logic              pt_we;
  logic [PAGE_W-1:0] pt_waddr;
  logic [PAGE_W:0]   pt_wdata;
  logic [PAGE_W:0]   pt_rdata;
  logic              pt_valid;
  logic [PAGE_W-1:0] pt_frame;

  // backing store and physical memory
  logic              bs_we;
  logic [MEM_AW-1:0] bs_waddr;
  logic              bs_re;
  logic [MEM_AW-1:0] bs_raddr;
  logic [BYTE_W-1:0] bs_rdata;
  logic              pm_we;
  logic [MEM_AW-1:0] pm_waddr;
  logic              pm_re;
  logic [MEM_AW-1:0] pm_raddr;
  logic [BYTE_W-1:0] pm_rdata;
  logic [31:0]       paddr_ext;

  logic              fault_now;
  logic [PAGE_W-1:0] frame_sel;
  logic              out_load;

  assign pt_valid      = pt_rdata[PAGE_W];
  assign pt_frame      = pt_rdata[PAGE_W-1:0];
  assign tlb_frame_ext = 32'(tlb_rsp.frame);
  assign page_ext      = 32'(page);
  assign frame_sel_ext = 32'(frame_sel);
  assign paddr_ext     = 32'({frame, offset});
  assign copy_cnt_m1   = copy_cnt - 1'b1;
  assign fault_now     = (state == S_RESOLVE) && !tlb_rsp.hit && !pt_valid;

  always_comb begin
    if (tlb_rsp.hit) begin
      frame_sel = tlb_frame_ext[PAGE_W-1:0];
    end else if (pt_valid) begin
      frame_sel = pt_frame;
    end else begin
      frame_sel = next_free_frame[PAGE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next         = state;
    s_axis_tready      = 1'b0;
    tlb_req.lookup     = do_lookup;
    tlb_req.lookup_tag = page_in_ext[TAG_W-1:0];
    tlb_req.fill       = 1'b0;
    tlb_req.fill_tag   = page_ext[TAG_W-1:0];
    tlb_req.fill_frame = frame_sel_ext[TAG_W-1:0];
    pt_we              = 1'b0;
    pt_waddr           = page;
    pt_wdata           = {1'b1, frame_sel};
    bs_we              = do_load;
    bs_waddr           = ld_ext[MEM_AW-1:0];
    bs_re              = 1'b0;
    bs_raddr           = {page, copy_cnt[OFF_W-1:0]};
    pm_we              = 1'b0;
    pm_waddr           = {frame, copy_cnt_m1[OFF_W-1:0]};
    pm_re              = 1'b0;
    pm_raddr           = {frame_sel, offset};
    out_load           = 1'b0;
    unique case (state)
      S_CLEAR: begin
        pt_we    = 1'b1;
        pt_waddr = clear_cnt;
        pt_wdata = '0;
        if (clear_cnt == PAGE_W'(PAGE_COUNT - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        s_axis_tready = 1'b1;
        if (do_lookup) begin
          state_next = S_RESOLVE;
        end
      end
      S_RESOLVE: begin
        tlb_req.fill = !tlb_rsp.hit;
        pt_we        = fault_now;
        if (fault_now) begin
          state_next = S_COPY;
        end else begin
          pm_re      = 1'b1;
          state_next = S_READ;
        end
      end
      S_COPY: begin
        bs_re = (copy_cnt != (OFF_W + 1)'(PAGE_BYTES));
        pm_we = (copy_cnt != '0);
        if (copy_cnt == (OFF_W + 1)'(PAGE_BYTES)) begin
          state_next = S_FETCH;
        end
      end
      S_FETCH: begin
        pm_re      = 1'b1;
        pm_raddr   = {frame, offset};
        state_next = S_READ;
      end
      S_READ: begin
        if (!out_valid || m_axis_tready) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      next_free_frame <= '0;
      hit_count       <= '0;
      fault_count     <= '0;
      clear_cnt       <= '0;
      copy_cnt        <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (state == S_CLEAR) begin
        clear_cnt <= clear_cnt + 1'b1;
      end
      if (state == S_RESOLVE) begin
        copy_cnt <= '0;
        if (tlb_rsp.hit) begin
          hit_count <= hit_count + 1'b1;
        end
        if (fault_now) begin
          fault_count <= fault_count + 1'b1;
          if (next_free_frame != (PAGE_W + 1)'(PAGE_COUNT)) begin
            next_free_frame <= next_free_frame + 1'b1;
          end
        end
      end
      if (state == S_COPY) begin
        copy_cnt <= copy_cnt + 1'b1;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_lookup) begin
      page   <= page_in;
      offset <= offset_in;
    end
    if (state == S_RESOLVE) begin
      frame      <= frame_sel;
      hit_flag   <= tlb_rsp.hit;
      fault_flag <= fault_now;
    end
    if (out_load) begin
      out_paddr       <= paddr_ext[ADDR_W-1:0];
      out_data        <= pm_rdata;
      out_hit         <= hit_flag;
      out_fault       <= fault_flag;
      out_hit_count   <= hit_count;
      out_fault_count <= fault_count;
    end
  end

  tlbpt_tlb #(
    .TLB_ENTRIES (TLB_ENTRIES)
  ) u_tlb (
    .clk (clk),
    .rst (rst),
    .req (tlb_req),
    .rsp (tlb_rsp)
  );

  tlbpt_ram #(
    .WIDTH (PAGE_W + 1),
    .DEPTH (PAGE_COUNT),
    .AW    (PAGE_W)
  ) u_page_table (
    .clk   (clk),
    .we    (pt_we),
    .waddr (pt_waddr),
    .wdata (pt_wdata),
    .re    (do_lookup),
    .raddr (page_in),
    .rdata (pt_rdata)
  );

  tlbpt_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (MEM_BYTES),
    .AW    (MEM_AW)
  ) u_backing_store (
    .clk   (clk),
    .we    (bs_we),
    .waddr (bs_waddr),
    .wdata (in_ld_data),
    .re    (bs_re),
    .raddr (bs_raddr),
    .rdata (bs_rdata)
  );

  tlbpt_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (MEM_BYTES),
    .AW    (MEM_AW)
  ) u_physical_memory (
    .clk   (clk),
    .we    (pm_we),
    .waddr (pm_waddr),
    .wdata (bs_rdata),
    .re    (pm_re),
    .raddr (pm_raddr),
    .rdata (pm_rdata)
  );

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, out_fault_count, out_hit_count,
                          out_fault, out_hit, out_data, out_paddr};

  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !(out_hit && out_fault))
    else $error("result flags both hit and fault");

  assert property (@(posedge clk) disable iff (rst)
    (fault_now && next_free_frame != (PAGE_W + 1)'(PAGE_COUNT))
      |=> next_free_frame == $past(next_free_frame) + 1'b1)
    else $error("free frame did not advance on fault");

  assert property (@(posedge clk) disable iff (rst)
    (state == S_COPY) |-> (copy_cnt <= (OFF_W + 1)'(PAGE_BYTES)))
    else $error("page copy ran past page end");

  assert property (@(posedge clk) disable iff (rst)
    (state == S_RESOLVE && !tlb_rsp.hit) |=> (hit_count == $past(hit_count)))
    else $error("hit counted on TLB miss");

endmodule

`default_nettype wire
